>>> rtl/twdt_pkg.sv
package twdt_pkg;

   localparam int COUNT_BITS_DEFAULT = 20;
   localparam int DATA_BITS          = 32;
   localparam int OFFSET_BITS        = 5;
   localparam int KIND_BITS          = 2;
   localparam int STATUS_SHIFT       = 3;

   localparam logic [KIND_BITS-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd2;

   localparam logic [OFFSET_BITS-1:0] OFS_RESTART = 5'h04;
   localparam logic [OFFSET_BITS-1:0] OFS_ENABLE  = 5'h08;
   localparam logic [OFFSET_BITS-1:0] OFS_STATUS  = 5'h0C;
   localparam logic [OFFSET_BITS-1:0] OFS_BARK    = 5'h10;
   localparam logic [OFFSET_BITS-1:0] OFS_BITE    = 5'h14;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [OFFSET_BITS-1:0] reg_offset;
      logic [DATA_BITS-1:0]   write_data;
   } item_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_data;
      logic                 bark_flag;
      logic                 bite_reset;
   } result_type;

endpackage

>>> rtl/two_stage_watchdog_timer.sv
// Two-stage watchdog timer with a bark (sticky warning) and a bite (one-shot reset pulse).
// Request channel (req_*): one transaction per tick, register write or register read,
// qualified by req_valid and held while req_stall is high.
// Response channel (rsp_*): exactly one transaction per request, in order, carrying
// read data (zero unless a read), the bark level and the bite pulse.
// A request is held in the input register, its result in the response register; the
// counter, limit compares and register decode run combinationally between the two.
// Throughput: one transaction per cycle unless the receiver stalls.
// When the receiver stalls, the response holds and one more request is buffered in the
// input register; req_stall rises only once that register is full and cannot drain.
// Reset (synchronous): counter, enable, both limits and both flags clear, and both
// channels go empty.
module two_stage_watchdog_timer #(
   parameter int COUNT_BITS = twdt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [twdt_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [twdt_pkg::OFFSET_BITS-1:0]   req_reg_offset,
   input  logic [twdt_pkg::DATA_BITS-1:0]     req_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [twdt_pkg::DATA_BITS-1:0]     rsp_read_data,
   output logic                               rsp_bark_flag,
   output logic                               rsp_bite_reset
);

   logic                 in_valid_ff, in_valid_in;
   twdt_pkg::item_type   item_ff;
   logic                 out_valid_ff, out_valid_in;
   twdt_pkg::result_type result_ff;
   twdt_pkg::result_type core_result;
   logic                 advance;
   logic                 req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)         out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   twdt_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.kind       <= req_kind;
         item_ff.reg_offset <= req_reg_offset;
         item_ff.write_data <= req_write_data;
      end
      if (advance) result_ff <= core_result;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_data  = result_ff.read_data;
   assign rsp_bark_flag  = result_ff.bark_flag;
   assign rsp_bite_reset = result_ff.bite_reset;

endmodule

>>> rtl/twdt_core.sv
module twdt_core #(
   parameter int COUNT_BITS = twdt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  twdt_pkg::item_type   item,
   output twdt_pkg::result_type result
);

   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  enable_ff, enable_in;
   logic [COUNT_BITS-1:0] bark_limit_ff, bark_limit_in;
   logic [COUNT_BITS-1:0] bite_limit_ff, bite_limit_in;
   logic                  bark_seen_ff, bark_seen_in;
   logic                  bite_fired_ff, bite_fired_in;

   logic [COUNT_BITS-1:0]          next_count;
   logic [COUNT_BITS-1:0]          sat_data;
   logic [twdt_pkg::DATA_BITS-1:0] rd_data;
   logic                           pulse;

   // limits clamp to the count range
   assign sat_data = (|item.write_data[twdt_pkg::DATA_BITS-1:COUNT_BITS]) ? CountMax
                   : item.write_data[COUNT_BITS-1:0];

   assign next_count = (count_ff != CountMax) ? count_ff + COUNT_BITS'(1) : count_ff;

   always_comb begin
      count_in      = count_ff;
      enable_in     = enable_ff;
      bark_limit_in = bark_limit_ff;
      bite_limit_in = bite_limit_ff;
      bark_seen_in  = bark_seen_ff;
      bite_fired_in = bite_fired_ff;
      rd_data       = '0;
      pulse         = 1'b0;
      unique case (item.kind)
         twdt_pkg::KIND_TICK: begin
            if (enable_ff) begin
               count_in = next_count;
               if (next_count >= bark_limit_ff) bark_seen_in = 1'b1;
               if (next_count >= bite_limit_ff && !bite_fired_ff) begin
                  bite_fired_in = 1'b1;
                  pulse         = 1'b1;
               end
            end
         end
         twdt_pkg::KIND_WRITE: begin
            unique case (item.reg_offset)
               twdt_pkg::OFS_RESTART: begin
                  if (item.write_data[0]) begin
                     count_in      = '0;
                     bark_seen_in  = 1'b0;
                     bite_fired_in = 1'b0;
                  end
               end
               twdt_pkg::OFS_ENABLE: enable_in     = item.write_data[0];
               twdt_pkg::OFS_BARK:   bark_limit_in = sat_data;
               twdt_pkg::OFS_BITE:   bite_limit_in = sat_data;
               default: ;
            endcase
         end
         twdt_pkg::KIND_READ: begin
            unique case (item.reg_offset)
               twdt_pkg::OFS_ENABLE: rd_data = twdt_pkg::DATA_BITS'(enable_ff);
               twdt_pkg::OFS_STATUS:
                  rd_data = twdt_pkg::DATA_BITS'(count_ff) << twdt_pkg::STATUS_SHIFT;
               twdt_pkg::OFS_BARK:   rd_data = twdt_pkg::DATA_BITS'(bark_limit_ff);
               twdt_pkg::OFS_BITE:   rd_data = twdt_pkg::DATA_BITS'(bite_limit_ff);
               default:              rd_data = '0;
            endcase
         end
         default: ;
      endcase
   end

   assign result.read_data  = rd_data;
   assign result.bark_flag  = bark_seen_in;
   assign result.bite_reset = pulse;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         enable_ff     <= 1'b0;
         bark_limit_ff <= '0;
         bite_limit_ff <= '0;
         bark_seen_ff  <= 1'b0;
         bite_fired_ff <= 1'b0;
      end else if (step_en) begin
         count_ff      <= count_in;
         enable_ff     <= enable_in;
         bark_limit_ff <= bark_limit_in;
         bite_limit_ff <= bite_limit_in;
         bark_seen_ff  <= bark_seen_in;
         bite_fired_ff <= bite_fired_in;
      end
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int COUNT_BITS = twdt_pkg::COUNT_BITS_DEFAULT;
   localparam int KB = twdt_pkg::KIND_BITS;
   localparam int OB = twdt_pkg::OFFSET_BITS;
   localparam int DB = twdt_pkg::DATA_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [KB-1:0] KIND_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS = 100;

   typedef struct packed {
      logic [KB-1:0] kind;
      logic [OB-1:0] ofs;
      logic [DB-1:0] data;
      logic          typed;
      logic [DB-1:0] rd;
      logic          bark;
      logic          bite;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [KB-1:0] req_kind = '0;
   logic [OB-1:0] req_reg_offset = '0;
   logic [DB-1:0] req_write_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [DB-1:0] rsp_read_data;
   logic          rsp_bark_flag;
   logic          rsp_bite_reset;

   // watchdog state as the predictor sees it
   logic [COUNT_BITS-1:0] wd_count = '0;
   logic                  wd_enabled = 1'b0;
   logic [COUNT_BITS-1:0] wd_bark_limit = '0;
   logic [COUNT_BITS-1:0] wd_bite_limit = '0;
   logic                  wd_barked = 1'b0;
   logic                  wd_bitten = 1'b0;

   twdt_pkg::result_type expected_results[$];
   int                   mismatches = 0;
   int                   quiet_cycles = 0;
   int                   sender_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   holds_asked = 0;
   int                   holds_done = 0;
   bit                   row_typed = 1'b0;
   twdt_pkg::result_type row_result = '0;

   stim_row_type directed_rows [0:24] = '{
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_ENABLE,  32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_STATUS,  32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_BARK,    32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_BITE,    32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_TICK,  5'h00,                 32'h0, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_BARK,    32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_BARK,    32'h0, 1'b1, 32'h000F_FFFF, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_BITE,    32'h0010_0000, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_BITE,    32'h0, 1'b1, 32'h000F_FFFF, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_BARK,    32'h2, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_BITE,    32'h3, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_ENABLE,  32'hFFFF_FFFE, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_TICK,  5'h1F,                 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_ENABLE,  32'h1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_TICK,  5'h00,                 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_TICK,  5'h00,                 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_TICK,  5'h00,                 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_TICK,  5'h00,                 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  twdt_pkg::OFS_STATUS,  32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_RESTART, 32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_STATUS,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_READ,  5'h05,                 32'h0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, 5'h1F,                 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0},
      '{twdt_pkg::KIND_WRITE, twdt_pkg::OFS_RESTART, 32'h1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{KIND_UNUSED,          5'h1F,                 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 1'b0}
   };

   two_stage_watchdog_timer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_reg_offset (req_reg_offset),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_bark_flag  (rsp_bark_flag),
      .rsp_bite_reset (rsp_bite_reset)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [COUNT_BITS-1:0] clamp_limit(input logic [DB-1:0] v);
      return (v > DB'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_BITS-1:0];
   endfunction

   function automatic twdt_pkg::result_type advance_watchdog(input logic [KB-1:0] kind,
                                                             input logic [OB-1:0] ofs,
                                                             input logic [DB-1:0] data);
      twdt_pkg::result_type res;
      res = '0;
      case (kind)
         twdt_pkg::KIND_TICK: begin
            if (wd_enabled) begin
               if (wd_count != COUNT_MAX) wd_count = wd_count + COUNT_BITS'(1);
               if (wd_count >= wd_bark_limit) wd_barked = 1'b1;
               if (wd_count >= wd_bite_limit && !wd_bitten) begin
                  wd_bitten = 1'b1;
                  res.bite_reset = 1'b1;
               end
            end
         end
         twdt_pkg::KIND_WRITE: begin
            case (ofs)
               twdt_pkg::OFS_RESTART: begin
                  if (data[0]) begin
                     wd_count = '0;
                     wd_barked = 1'b0;
                     wd_bitten = 1'b0;
                  end
               end
               twdt_pkg::OFS_ENABLE: wd_enabled = data[0];
               twdt_pkg::OFS_BARK: wd_bark_limit = clamp_limit(data);
               twdt_pkg::OFS_BITE: wd_bite_limit = clamp_limit(data);
               default: ;
            endcase
         end
         twdt_pkg::KIND_READ: begin
            case (ofs)
               twdt_pkg::OFS_ENABLE: res.read_data = DB'(wd_enabled);
               twdt_pkg::OFS_STATUS:
                  res.read_data = DB'(wd_count) << twdt_pkg::STATUS_SHIFT;
               twdt_pkg::OFS_BARK: res.read_data = DB'(wd_bark_limit);
               twdt_pkg::OFS_BITE: res.read_data = DB'(wd_bite_limit);
               default: ;
            endcase
         end
         default: ;
      endcase
      res.bark_flag = wd_barked;
      return res;
   endfunction

   // compare completed transactions, predict accepted ones, watch for a hang
   always @(posedge clock) begin
      twdt_pkg::result_type want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, actual read_data %h bark %b bite %b",
                        $time, rsp_read_data, rsp_bark_flag, rsp_bite_reset);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_read_data);
                  mismatches++;
               end
               if (rsp_bark_flag !== want.bark_flag) begin
                  $display("%0t: bark_flag expected %b actual %b",
                           $time, want.bark_flag, rsp_bark_flag);
                  mismatches++;
               end
               if (rsp_bite_reset !== want.bite_reset) begin
                  $display("%0t: bite_reset expected %b actual %b",
                           $time, want.bite_reset, rsp_bite_reset);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want = advance_watchdog(req_kind, req_reg_offset, req_write_data);
            if (row_typed) want = row_result;
            expected_results.push_back(want);
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (holds_done < holds_asked) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic offer_item(input logic [KB-1:0] k, input logic [OB-1:0] o,
                             input logic [DB-1:0] d, input bit typed,
                             input twdt_pkg::result_type typed_res);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind <= k;
      req_reg_offset <= o;
      req_write_data <= d;
      req_valid <= 1'b1;
      row_typed = typed;
      row_result = typed_res;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic run_phase(input int s_pct, input int r_pct);
      logic [KB-1:0]        k;
      logic [OB-1:0]        o;
      logic [DB-1:0]        d;
      int                   sel;
      twdt_pkg::result_type none;
      none = '0;
      sender_idle_pct = s_pct;
      recv_stall_pct = r_pct;
      repeat (PHASE_ITEMS) begin
         sel = $urandom_range(99);
         o = OB'($urandom);
         d = $urandom;
         if (sel < 50) begin
            k = twdt_pkg::KIND_TICK;
         end else if (sel < 75) begin
            k = twdt_pkg::KIND_WRITE;
            case ($urandom_range(9))
               0, 1: begin
                  o = twdt_pkg::OFS_RESTART;
                  d[0] = ($urandom_range(3) != 0);
               end
               2: begin
                  o = twdt_pkg::OFS_ENABLE;
                  d[0] = ($urandom_range(9) != 0);
               end
               3, 4, 5: begin
                  o = twdt_pkg::OFS_BARK;
                  if ($urandom_range(9) != 0) d = $urandom_range(24);
               end
               6, 7: begin
                  o = twdt_pkg::OFS_BITE;
                  if ($urandom_range(9) != 0) d = $urandom_range(32);
               end
               8: o = twdt_pkg::OFS_STATUS;
               default: ;
            endcase
         end else if (sel < 95) begin
            k = twdt_pkg::KIND_READ;
            case ($urandom_range(5))
               0: o = twdt_pkg::OFS_ENABLE;
               1: o = twdt_pkg::OFS_STATUS;
               2: o = twdt_pkg::OFS_BARK;
               3: o = twdt_pkg::OFS_BITE;
               4: o = twdt_pkg::OFS_RESTART;
               default: ;
            endcase
         end else begin
            k = KIND_UNUSED;
         end
         offer_item(k, o, d, 1'b0, none);
      end
   endtask

   initial begin
      twdt_pkg::result_type typed_res;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_res.read_data = directed_rows[i].rd;
         typed_res.bark_flag = directed_rows[i].bark;
         typed_res.bite_reset = directed_rows[i].bite;
         offer_item(directed_rows[i].kind, directed_rows[i].ofs, directed_rows[i].data,
                    directed_rows[i].typed, typed_res);
      end

      run_phase(0, 0);
      run_phase(75, 0);
      run_phase(0, 75);
      run_phase(18, 18);
      // long receiver hold-off while the sender keeps pushing
      holds_asked++;
      run_phase(0, 0);

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
